### sv/ritoa_pkg.sv
// Shared constants, types and helper functions of the radix integer-to-ASCII block.
package ritoa_pkg;

  localparam int MAX_DIGITS = 64;
  localparam int DIG_AW     = $clog2(MAX_DIGITS);
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

  localparam int VAL_W  = 64;
  localparam int BYTE_W = 8;
  localparam int NBYTES = VAL_W / BYTE_W;
  localparam int NB_W   = $clog2(NBYTES + 1);
  localparam int POS_W  = $clog2(NBYTES);

  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] DEC_DIGITS  = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_A      = 7'h41;

  // job queue between front and back
  localparam int JQ_DEPTH = 2;
  localparam int JQ_AW    = $clog2(JQ_DEPTH);
  localparam int JQ_CW    = $clog2(JQ_DEPTH + 1);

  // result queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic             neg;
    logic [VAL_W-1:0] mag;
    logic [NB_W-1:0]  nbytes;   // significant bytes of mag, 0 for zero
  } job_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              minus_before;
    logic              last;
  } out_item_t;

  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    if (r < RADIX_MIN) return RADIX_MIN;
    if (r > RADIX_MAX) return RADIX_MAX;
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] ascii_of(input logic [RADIX_W-1:0] d);
    if (d < DEC_DIGITS) return CHAR_ZERO + CHAR_W'(d);
    return CHAR_A + CHAR_W'(d - DEC_DIGITS);
  endfunction

endpackage

### sv/ritoa_front.sv
// Front end: takes input items, splits sign and magnitude, sizes it, queues jobs.
module ritoa_front import ritoa_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    job_valid,
  output job_t                    job,
  input  logic                    job_pop
);

  logic [VAL_W-1:0] raw;
  job_t             cls;
  logic             accept;

  job_t             jq_mem [JQ_DEPTH];
  logic [JQ_AW-1:0] wr_ptr_r;
  logic [JQ_AW-1:0] rd_ptr_r;
  logic [JQ_CW-1:0] cnt_r;

  assign raw = in_value;

  always_comb begin
    cls.neg    = raw[VAL_W-1];
    cls.mag    = cls.neg ? (VAL_W'(0) - raw) : raw;
    cls.nbytes = '0;
    for (int i = 0; i < NBYTES; i++) begin
      if (cls.mag[BYTE_W*i +: BYTE_W] != '0) cls.nbytes = NB_W'(i + 1);
    end
  end

  assign in_full   = (cnt_r == JQ_CW'(JQ_DEPTH));
  assign accept    = in_push && !in_full;
  assign job_valid = (cnt_r != '0);
  assign job       = jq_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (accept) jq_mem[wr_ptr_r] <= cls;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (accept) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (job_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + JQ_CW'(accept) - JQ_CW'(job_pop);
    end
  end

endmodule

### sv/ritoa_back.sv
// Back end: byte-serial division by the radix into a digit store, then emission.
module ritoa_back import ritoa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [RADIX_W-1:0] radix,
  input  logic               job_valid,
  input  job_t               job,
  output logic               job_pop,
  input  logic [OQ_CW-1:0]   oq_count,
  output logic               oq_push,
  output out_item_t          oq_item
);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} state_t;

  state_t             state_r;
  logic [VAL_W-1:0]   mag_r;
  logic [NB_W-1:0]    nb_r;
  logic [POS_W-1:0]   pos_r;
  logic [RADIX_W-1:0] rem_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               neg_r;
  logic               first_r;
  logic [DIG_AW-1:0]  rd_idx_r;
  logic               rd_vld_r;
  logic               rd_minus_r;
  logic               rd_last_r;
  logic [RADIX_W-1:0] rd_data_r;

  logic [RADIX_W-1:0] dig_mem [MAX_DIGITS];
  logic               mem_we;
  logic [DIG_AW-1:0]  mem_wa;
  logic [RADIX_W-1:0] mem_wd;
  logic               issue;

  logic [RADIX_W-1:0] base;
  logic [BYTE_W-1:0]  cur_byte;
  logic [BYTE_W-1:0]  q_byte;
  logic [RADIX_W-1:0] rem_step;
  logic [RADIX_W:0]   part;
  logic [VAL_W-1:0]   mag_upd;
  logic [POS_W-1:0]   top_idx;
  logic [NB_W-1:0]    nb_dec;
  logic [CNT_W-1:0]   cnt_inc;
  logic               div_done;

  assign base     = eff_radix(radix);
  assign cur_byte = mag_r[BYTE_W*pos_r +: BYTE_W];

  // eight restoring steps on one dividend byte
  always_comb begin
    rem_step = rem_r;
    q_byte   = '0;
    part     = '0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      part = {rem_step, cur_byte[i]};
      if (part >= {1'b0, base}) begin
        q_byte[i] = 1'b1;
        rem_step  = RADIX_W'(part - {1'b0, base});
      end else begin
        rem_step  = part[RADIX_W-1:0];
      end
    end
  end

  // quotient loses at most one byte per digit since radix < 256
  always_comb begin
    mag_upd                            = mag_r;
    mag_upd[BYTE_W*pos_r +: BYTE_W]    = q_byte;
    top_idx                            = POS_W'(nb_r - 1'b1);
    nb_dec = (mag_upd[BYTE_W*top_idx +: BYTE_W] == '0) ? (nb_r - 1'b1) : nb_r;
  end

  assign cnt_inc  = cnt_r + 1'b1;
  assign div_done = (nb_dec == '0) || (cnt_inc == CNT_W'(MAX_DIGITS));

  assign job_pop = (state_r == ST_IDLE) && job_valid;
  assign issue   = (state_r == ST_EMIT) &&
                   (((OQ_CW+1)'(oq_count) + (OQ_CW+1)'(rd_vld_r)) < (OQ_CW+1)'(OQ_DEPTH));

  always_comb begin
    mem_we = 1'b0;
    mem_wa = DIG_AW'(cnt_r);
    mem_wd = rem_step;
    if (job_pop && (job.nbytes == '0)) begin
      mem_we = 1'b1;
      mem_wa = '0;
      mem_wd = '0;
    end else if ((state_r == ST_DIV) && (pos_r == '0)) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) dig_mem[mem_wa] <= mem_wd;
    if (issue) rd_data_r <= dig_mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (job_valid) begin
            neg_r <= job.neg;
            mag_r <= job.mag;
            nb_r  <= job.nbytes;
            rem_r <= '0;
            pos_r <= POS_W'(job.nbytes - 1'b1);
            if (job.nbytes == '0) begin
              cnt_r    <= CNT_W'(1);
              rd_idx_r <= '0;
              first_r  <= 1'b1;
              state_r  <= ST_EMIT;
            end else begin
              cnt_r    <= '0;
              state_r  <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          mag_r <= mag_upd;
          if (pos_r == '0) begin
            cnt_r <= cnt_inc;
            nb_r  <= nb_dec;
            rem_r <= '0;
            pos_r <= POS_W'(nb_dec - 1'b1);
            if (div_done) begin
              rd_idx_r <= DIG_AW'(cnt_r);
              first_r  <= 1'b1;
              state_r  <= ST_EMIT;
            end
          end else begin
            pos_r <= pos_r - 1'b1;
            rem_r <= rem_step;
          end
        end
        ST_EMIT: begin
          if (issue) begin
            rd_vld_r   <= 1'b1;
            rd_minus_r <= first_r && neg_r;
            rd_last_r  <= (rd_idx_r == '0);
            first_r    <= 1'b0;
            rd_idx_r   <= rd_idx_r - 1'b1;
            if (rd_idx_r == '0) state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign oq_push              = rd_vld_r;
  assign oq_item.digit_char   = ascii_of(rd_data_r);
  assign oq_item.minus_before = rd_minus_r;
  assign oq_item.last         = rd_last_r;

endmodule

### sv/ritoa_ofifo.sv
// Result queue: holds emitted characters until the receiver pops them.
module ritoa_ofifo import ritoa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  out_item_t        item_in,
  input  logic             pop,
  output logic             empty,
  output out_item_t        item_out,
  output logic [OQ_CW-1:0] count
);

  out_item_t        mem [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_r;
  logic [OQ_AW-1:0] rd_ptr_r;
  logic [OQ_CW-1:0] cnt_r;
  logic             do_pop;

  assign empty    = (cnt_r == '0);
  assign count    = cnt_r;
  assign item_out = mem[rd_ptr_r];
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= item_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + OQ_CW'(push) - OQ_CW'(do_pop);
    end
  end

endmodule

### sv/radix_integer_to_ascii_top.sv
// Top level of the radix integer-to-ASCII converter.
// Usage:
//   Input queue: drive in_value and raise in_push; the item is taken at a
//   clock edge where in_push is high and in_full is low. A two-item job
//   queue sits behind the front end, so new numbers are taken while the
//   back end is still busy.
//   Result queue: while out_empty is low, out_digit_char/out_minus_before/
//   out_last show the oldest character; out_pop takes it. Characters come
//   most significant first; out_minus_before flags the first character of a
//   negative number, out_last its final character.
//   Config: cfg_radix is written when cfg_valid is high (cfg_ready is always
//   high). Values below 2 act as 2, above 36 act as 36. Reset value is 10.
//   Write it only while no number is in flight.
// Timing: each digit takes one division pass over the significant bytes of
//   the remaining magnitude (8 quotient bits per cycle in the divider), then
//   the digits are emitted in turn, waiting while the result queue is full.
//   After division ends, the first character is read from the digit store
//   into a register and pushed into the result queue.
// Reset (rst_n low, synchronous) empties both queues, radix back to 10.
//   On a receiver stall the back end waits; two more numbers queue, then in_full.
module radix_integer_to_ascii_top import ritoa_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic [CHAR_W-1:0]       out_digit_char,
  output logic                    out_minus_before,
  output logic                    out_last,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [RADIX_W-1:0]      cfg_radix
);

  logic [RADIX_W-1:0] radix_r;
  logic               job_valid;
  job_t               job;
  logic               job_pop;
  logic [OQ_CW-1:0]   oq_count;
  logic               oq_push;
  out_item_t          oq_item;
  out_item_t          oq_head;

  // radix register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radix_r <= cfg_radix;
    end
  end

  ritoa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_value  (in_value),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop)
  );

  ritoa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .radix     (radix_r),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .oq_count  (oq_count),
    .oq_push   (oq_push),
    .oq_item   (oq_item)
  );

  ritoa_ofifo u_ofifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (oq_push),
    .item_in  (oq_item),
    .pop      (out_pop),
    .empty    (out_empty),
    .item_out (oq_head),
    .count    (oq_count)
  );

  assign out_digit_char   = oq_head.digit_char;
  assign out_minus_before = oq_head.minus_before;
  assign out_last         = oq_head.last;

endmodule

### sv/ritoa_chk.sv
// Port-level checker for the radix integer-to-ASCII top level, with its bind.
module ritoa_chk import ritoa_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_empty,
  input logic                    out_pop,
  input logic [CHAR_W-1:0]       out_digit_char,
  input logic                    out_minus_before,
  input logic                    out_last
);

  // no result right out of reset
  a_empty_after_reset: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> out_empty)
    else $error("result shown right after reset");

  // a shown, stalled result holds
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_digit_char) &&
      $stable(out_minus_before) && $stable(out_last)))
    else $error("stalled result changed");

  // characters are digits or capitals only
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> ((out_digit_char >= CHAR_ZERO && out_digit_char < CHAR_ZERO + 7'd10) ||
                    (out_digit_char >= CHAR_A && out_digit_char <= CHAR_A + 7'd25)))
    else $error("character outside digit set");

  // minus flag only on the first character of a number
  a_minus_first_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && !out_last) |=> (out_empty || !out_minus_before))
    else $error("minus flag inside a number");

endmodule

bind radix_integer_to_ascii_top ritoa_chk u_ritoa_chk (.*);
